// File: rtl/sib_pkg.sv
`default_nettype none

package sib_pkg;

  // Store geometry.
  localparam int DEPTH   = 32;
  localparam int VALUE_W = 31;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // Input action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_END    = 1'b1;

  // Control states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Operation broadcast to every cell in the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [VALUE_W-1:0]     ins_value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sib_cell.sv
`default_nettype none

module sib_cell
  import sib_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               occ,
  input  wire logic               left_take,
  input  wire logic [VALUE_W-1:0] left_value,
  input  wire logic [VALUE_W-1:0] right_value,
  output logic                    take,
  output logic [VALUE_W-1:0]      value
);

  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;

  // This cell sits at or past the insert point when it is empty or holds a
  // value that is not below the new one.
  assign take  = !occ || (value_r >= ctrl.ins_value);
  assign value = value_r;

  // An insert takes the new value at the insert point and the left
  // neighbor's value past it; a drain shifts every value one cell down.
  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (take) begin
          value_nxt = left_take ? left_value : ctrl.ins_value;
        end
      end
      CELL_SHIFT: begin
        value_nxt = right_value;
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/sib_chain.sv
`default_nettype none

module sib_chain
  import sib_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [COUNT_W-1:0] count,
  output logic [VALUE_W-1:0]      head_value
);

  logic [DEPTH-1:0]   take;
  logic [VALUE_W-1:0] value [DEPTH];

  // One cell per store entry; take and values pass between neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               occ;
    logic               l_take;
    logic [VALUE_W-1:0] l_value;
    logic [VALUE_W-1:0] r_value;

    assign occ = COUNT_W'(i) < count;

    if (i == 0) begin : g_first
      assign l_take  = 1'b0;
      assign l_value = '0;
    end else begin : g_inner
      assign l_take  = take[i-1];
      assign l_value = value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_value = '0;
    end else begin : g_mid
      assign r_value = value[i+1];
    end

    sib_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_take   (l_take),
      .left_value  (l_value),
      .right_value (r_value),
      .take        (take[i]),
      .value       (value[i])
    );
  end

  assign head_value = value[0];

endmodule

`default_nettype wire

// File: rtl/sorted_insertion_buffer.sv
// Insert beat: accepted when the input is not stalled; one beat per cycle.
// End beat with N stored values: N result beats, one per cycle while
// out_stall is low, the first loaded into the output register from the
// drain state; the input stalls during the drain.
// Synchronous active-low reset empties the store and clears the overflow
// flag and the output valid flag; stored values and the output payload are not cleared.
`default_nettype none

module sorted_insertion_buffer
  import sib_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_action,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VALUE_W-1:0]      out_value_res,
  output logic                    out_last,
  output logic                    out_overflow
);

  state_t             state_r;
  state_t             state_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               dropped_r;
  logic               dropped_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_last_r;
  logic               out_ovf_r;

  cell_ctrl_t         ctrl;
  logic [VALUE_W-1:0] head_value;
  logic               in_fire;
  logic               drain_go;
  logic               count_one;

  assign in_stall  = (state_r == ST_DRAIN);
  assign in_fire   = in_valid && !in_stall;
  assign drain_go  = !out_valid_r || !out_stall;
  assign count_one = (count_r == COUNT_W'(1));

  sib_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .count      (count_r),
    .head_value (head_value)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_action == ACT_END) && (count_r != '0)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_go && count_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Chain operation, fill count, overflow flag and output register loads.
  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.ins_value = in_value;
    count_nxt      = count_r;
    dropped_nxt    = dropped_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_INSERT) begin
            ctrl.op = CELL_INSERT;
            if (count_r == COUNT_W'(DEPTH)) begin
              dropped_nxt = 1'b1;
            end else begin
              count_nxt = count_r + COUNT_W'(1);
            end
          end else if (count_r == '0) begin
            dropped_nxt = 1'b0;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_go) begin
          ctrl.op       = CELL_SHIFT;
          count_nxt     = count_r - COUNT_W'(1);
          out_valid_nxt = 1'b1;
          if (count_one) begin
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        ctrl.op = CELL_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded from the head cell on each drain beat.
  always_ff @(posedge clk) begin
    if ((state_r == ST_DRAIN) && drain_go) begin
      out_value_r <= head_value;
      out_last_r  <= count_one;
      out_ovf_r   <= count_one && dropped_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

`default_nettype wire

// File: rtl/sib_checker.sv
`default_nettype none

module sib_checker
  import sib_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_action,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [VALUE_W-1:0] out_value_res,
  input wire logic               out_last,
  input wire logic               out_overflow
);

  // Overflow is only reported on the final beat of a drain.
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> out_last)
    else $error("overflow shown on a beat that is not last");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_value_res) && $stable(out_last) && $stable(out_overflow)))
    else $error("stalled result beat changed");

  // While a drain is still going, no new input beat is taken.
  a_drain_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input not stalled in the middle of a drain");

  // Reset clears the output valid flag.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // An accepted insert beat never starts a drain.
  a_insert_no_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action == ACT_INSERT) && !out_valid) |=> !out_valid)
    else $error("result beat appeared after an insert");

endmodule

bind sorted_insertion_buffer sib_checker u_sib_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_res (out_value_res),
  .out_last      (out_last),
  .out_overflow  (out_overflow)
);

`default_nettype wire
